// ===== rtl/core/rspe_pkg.sv =====
// Shared types, constants and GF(256) arithmetic for the Reed-Solomon parity encoder.
// No dependencies; every other file of the encoder imports this package.
`default_nettype none
package rspe_pkg;

	localparam int BYTE_W      = 8;
	localparam int CFG_W       = 6;
	localparam int DEF_MAX_PAR = 32;
	localparam int RESET_PAR   = 7;

	// Low byte of the field polynomial x^8+x^4+x^3+x^2+1; the x^8 term is implied.
	localparam logic [BYTE_W-1:0] GF_POLY_LO = 8'h1D;
	localparam logic [BYTE_W-1:0] GF_ONE     = 8'h01;

	// Per-cycle commands broadcast from the controller to every cell.
	typedef struct packed {
		logic build;   // one generator iteration: multiply by (x + root)
		logic clear;   // wipe generator and remainder before a rebuild
		logic advance; // a message byte was accepted
		logic load;    // that byte was the last one: capture parity, clear remainder
		logic shift;   // a parity beat left the output, move the parity row along
	} cell_ctl_t;

	function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] x);
		gf_xtime = {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? GF_POLY_LO : '0);
	endfunction

	// Shift-and-add product in GF(256), eight narrow dependent steps.
	function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
	                                             input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] x;
		acc = '0;
		x   = a;
		for (int k = 0; k < BYTE_W; k++) begin
			if (b[k]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x);
		end
		gf_mul = acc;
	endfunction

	// Parity count as used: zero means one, anything above the maximum means the maximum.
	function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] pc,
	                                                 input logic [CFG_W-1:0] max_n);
		if (pc == '0) begin
			clamp_count = CFG_W'(1);
		end else if (pc > max_n) begin
			clamp_count = max_n;
		end else begin
			clamp_count = pc;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/reed_solomon_parity_encoder.sv =====
// Top level of the systematic Reed-Solomon parity encoder over GF(256), polynomial 0x11D.
// Depends on rspe_pkg, rspe_ctrl and rspe_cell.
//
//   channel  | direction | beat                      | payload
//   ---------+-----------+---------------------------+---------------------------------
//   s_*      | in        | one message byte          | tdata = data_byte, tlast = last_byte
//   m_*      | out       | one parity byte           | tdata = parity_byte, tlast = last_parity
//   cfg_*    | in        | parity count write        | cfg_data = parity_count
//
// Message bytes are taken one per cycle while s_tready is high; the remainder row of
// cells updates in the same cycle the byte is accepted. On the last byte the updated
// remainder is copied into a parity row, which shifts out one byte per output beat, so
// the next message streams in while the parity of the previous one drains. A last byte
// waits unless the previous parity block is fully delivered or its final beat leaves now.
// After reset, and after every parity count write, the generator is rebuilt one root
// per cycle, during which neither input channel is ready.
`default_nettype none
module reed_solomon_parity_encoder #(
	parameter int MAX_PARITY = rspe_pkg::DEF_MAX_PAR
) (
	input  wire                         clk,
	input  wire                         arst_n,
	// Configuration: the parity count n, 1..MAX_PARITY (zero acts as one).
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire [rspe_pkg::CFG_W-1:0]   cfg_data,
	// Message stream.
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire [rspe_pkg::BYTE_W-1:0]  s_tdata,  // [7:0] data_byte
	input  wire                         s_tlast,  // last_byte
	// Parity stream, highest-order remainder byte first.
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [rspe_pkg::BYTE_W-1:0] m_tdata,  // [7:0] parity_byte
	output logic                        m_tlast   // last_parity
);
	import rspe_pkg::*;

	cell_ctl_t         ctl;
	logic [BYTE_W-1:0] root;
	logic [BYTE_W-1:0] feedback;
	logic [BYTE_W-1:0] coef_w [MAX_PARITY];
	logic [BYTE_W-1:0] rem_w  [MAX_PARITY];
	logic [BYTE_W-1:0] par_w  [MAX_PARITY];

	rspe_ctrl #(
		.MAX_PARITY(MAX_PARITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.ctl      (ctl),
		.root     (root)
	);

	// The feedback is the incoming byte plus the leading remainder byte; it reaches
	// every cell, each of which multiplies it by its own generator coefficient.
	assign feedback = s_tdata ^ rem_w[0];

	// Cell j holds coefficient j+1 of the monic generator and remainder byte j. Cells
	// beyond the active count keep zero coefficients and zero remainders, so the row
	// behaves as an n-byte register without any per-cell enable.
	for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
		logic [BYTE_W-1:0] coef_prev;
		logic [BYTE_W-1:0] rem_next;
		logic [BYTE_W-1:0] par_next;

		if (j == 0) begin : g_head
			assign coef_prev = GF_ONE;
		end else begin : g_body
			assign coef_prev = coef_w[j-1];
		end

		if (j == MAX_PARITY - 1) begin : g_tail
			assign rem_next = '0;
			assign par_next = '0;
		end else begin : g_link
			assign rem_next = rem_w[j+1];
			assign par_next = par_w[j+1];
		end

		rspe_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.root     (root),
			.feedback (feedback),
			.coef_prev(coef_prev),
			.rem_next (rem_next),
			.par_next (par_next),
			.coef     (coef_w[j]),
			.rem      (rem_w[j]),
			.par      (par_w[j])
		);
	end

	// The head of the parity row is the output register.
	assign m_tdata = par_w[0];

endmodule
`default_nettype wire

// ===== rtl/core/rspe_cell.sv =====
// One cell of the encoder row: a generator coefficient, a remainder byte and a parity byte.
// Depends on rspe_pkg for the command struct and the GF(256) multiplier.
`default_nettype none
module rspe_cell (
	input  wire                         clk,
	input  wire                         arst_n,
	input  rspe_pkg::cell_ctl_t         ctl,
	input  wire [rspe_pkg::BYTE_W-1:0]  root,
	input  wire [rspe_pkg::BYTE_W-1:0]  feedback,
	input  wire [rspe_pkg::BYTE_W-1:0]  coef_prev,
	input  wire [rspe_pkg::BYTE_W-1:0]  rem_next,
	input  wire [rspe_pkg::BYTE_W-1:0]  par_next,
	output logic [rspe_pkg::BYTE_W-1:0] coef,
	output logic [rspe_pkg::BYTE_W-1:0] rem,
	output logic [rspe_pkg::BYTE_W-1:0] par
);
	import rspe_pkg::*;

	logic [BYTE_W-1:0] coef_q;
	logic [BYTE_W-1:0] rem_q;
	logic [BYTE_W-1:0] par_q;
	logic [BYTE_W-1:0] mul_a;
	logic [BYTE_W-1:0] mul_b;
	logic [BYTE_W-1:0] prod;
	logic [BYTE_W-1:0] rem_upd;

	// The multiplier is shared: the generator build uses it while the block is idle.
	always_comb begin
		mul_a   = ctl.build ? coef_prev : coef_q;
		mul_b   = ctl.build ? root : feedback;
		prod    = gf_mul(mul_a, mul_b);
		rem_upd = rem_next ^ prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			rem_q  <= '0;
		end else begin
			if (ctl.clear) begin
				coef_q <= '0;
				rem_q  <= '0;
			end else begin
				if (ctl.build) begin
					coef_q <= coef_q ^ prod;
				end
				if (ctl.advance) begin
					rem_q <= ctl.load ? '0 : rem_upd;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q <= '0;
		end else if (ctl.load) begin
			par_q <= rem_upd;
		end else if (ctl.shift) begin
			par_q <= par_next;
		end
	end

	assign coef = coef_q;
	assign rem  = rem_q;
	assign par  = par_q;

endmodule
`default_nettype wire

// ===== rtl/core/rspe_ctrl.sv =====
// Controller of the encoder: generator build sequencing, parity beat count and handshakes.
// Depends on rspe_pkg for the command struct, the field helpers and the count clamp.
`default_nettype none
module rspe_ctrl #(
	parameter int MAX_PARITY = rspe_pkg::DEF_MAX_PAR
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire [rspe_pkg::CFG_W-1:0]   cfg_data,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire                         s_tlast,
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic                        m_tlast,
	output rspe_pkg::cell_ctl_t         ctl,
	output logic [rspe_pkg::BYTE_W-1:0] root
);
	import rspe_pkg::*;

	localparam int CW = $clog2(MAX_PARITY + 1);
	localparam int RESET_EFF = (RESET_PAR > MAX_PARITY) ? MAX_PARITY : RESET_PAR;
	localparam logic [CFG_W-1:0] MAX_N = CFG_W'(MAX_PARITY);
	localparam logic [CW-1:0]    RST_N = CW'(RESET_EFF);

	logic [CW-1:0]     n_q;
	logic [CW-1:0]     bld_cnt_q;
	logic [CW-1:0]     out_cnt_q;
	logic [BYTE_W-1:0] root_q;
	logic [CW-1:0]     n_new;
	logic              building;
	logic              cfg_acc;
	logic              in_acc;
	logic              out_acc;
	logic              buf_free;

	always_comb begin
		n_new    = CW'(clamp_count(cfg_data, MAX_N));
		building = (bld_cnt_q != '0);
		cfg_acc  = cfg_valid && cfg_ready;
		out_acc  = m_tvalid && m_tready;
		// The parity row can take a new block if empty or its final beat leaves now.
		buf_free = (out_cnt_q == '0) || ((out_cnt_q == CW'(1)) && m_tready);
		in_acc   = s_tvalid && s_tready;
	end

	always_comb begin
		cfg_ready   = !building;
		s_tready    = !building && (!s_tlast || buf_free);
		m_tvalid    = (out_cnt_q != '0);
		m_tlast     = (out_cnt_q == CW'(1));
		ctl.build   = building;
		ctl.clear   = cfg_acc;
		ctl.advance = in_acc;
		ctl.load    = in_acc && s_tlast;
		ctl.shift   = out_acc;
		root        = root_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= RST_N;
			bld_cnt_q <= RST_N;
			root_q    <= GF_ONE;
		end else if (cfg_acc) begin
			n_q       <= n_new;
			bld_cnt_q <= n_new;
			root_q    <= GF_ONE;
		end else if (building) begin
			bld_cnt_q <= bld_cnt_q - CW'(1);
			root_q    <= gf_xtime(root_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (ctl.load) begin
			out_cnt_q <= n_q;
		end else if (out_acc) begin
			out_cnt_q <= out_cnt_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

// ===== test/reed_solomon_parity_encoder_test.sv =====
// Self-checking testbench for reed_solomon_parity_encoder: message streams at several
// parity counts, every parity beat checked against a GF(256) remainder predictor.
// Depends on rspe_pkg (types and widths) and the encoder RTL; reads no files.

typedef struct packed {
	logic [rspe_pkg::BYTE_W-1:0] parity_byte;
	logic                        last_parity;
} parity_beat_t;

// Tracks the generator and the remainder of the message in progress, and holds the
// parity beats that the encoder still owes, oldest first.
class rs_parity_predictor;
	logic [7:0]   remainder [rspe_pkg::DEF_MAX_PAR];
	logic [7:0]   taps [rspe_pkg::DEF_MAX_PAR];
	int           n_active;
	parity_beat_t parity_due [$];
	int           mismatch_count;
	int           bytes_taken;
	int           messages_done;
	int           beats_matched;

	function new();
		mismatch_count = 0;
		bytes_taken    = 0;
		messages_done  = 0;
		beats_matched  = 0;
		set_parity_count(6'(rspe_pkg::RESET_PAR));
	endfunction

	// Horner form: walk the multiplier from its top bit, doubling the sum each step.
	static function logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] sum;
		sum = 8'h00;
		for (int i = 7; i >= 0; i--) begin
			sum = {sum[6:0], 1'b0} ^ (sum[7] ? rspe_pkg::GF_POLY_LO : 8'h00);
			if (b[i]) begin
				sum = sum ^ a;
			end
		end
		return sum;
	endfunction

	// Builds prod (x + a^i) for i < n and clears the remainder, as a register write does.
	function void set_parity_count(input logic [5:0] value);
		logic [7:0] poly [rspe_pkg::DEF_MAX_PAR + 1];
		logic [7:0] root;
		if (value == 6'd0) begin
			n_active = 1;
		end else if (value > rspe_pkg::DEF_MAX_PAR) begin
			n_active = rspe_pkg::DEF_MAX_PAR;
		end else begin
			n_active = int'(value);
		end
		foreach (poly[k]) begin
			poly[k] = 8'h00;
		end
		poly[0] = 8'h01;
		root    = 8'h01;
		for (int i = 0; i < n_active; i++) begin
			for (int j = i + 1; j >= 1; j--) begin
				poly[j] = poly[j] ^ gf_times(poly[j - 1], root);
			end
			root = gf_times(root, 8'h02);
		end
		for (int k = 0; k < rspe_pkg::DEF_MAX_PAR; k++) begin
			taps[k]      = (k < n_active) ? poly[k + 1] : 8'h00;
			remainder[k] = 8'h00;
		end
	endfunction

	function void take_message_byte(input logic [7:0] data, input logic last);
		logic [7:0]   feedback;
		parity_beat_t beat;
		feedback = data ^ remainder[0];
		for (int j = 0; j + 1 < n_active; j++) begin
			remainder[j] = remainder[j + 1];
		end
		remainder[n_active - 1] = 8'h00;
		for (int j = 0; j < n_active; j++) begin
			remainder[j] = remainder[j] ^ gf_times(taps[j], feedback);
		end
		bytes_taken++;
		if (last) begin
			for (int j = 0; j < n_active; j++) begin
				beat.parity_byte = remainder[j];
				beat.last_parity = (j == n_active - 1);
				parity_due.push_back(beat);
				remainder[j] = 8'h00;
			end
			messages_done++;
		end
	endfunction

	function void match_parity_beat(input logic [7:0] parity, input logic last);
		parity_beat_t want;
		if (parity_due.size() == 0) begin
			$error("parity beat 0x%02h (last %0b) arrived with none outstanding", parity, last);
			mismatch_count++;
			return;
		end
		want = parity_due.pop_front();
		if (want.parity_byte !== parity) begin
			$error("parity_byte: expected 0x%02h, actual 0x%02h", want.parity_byte, parity);
			mismatch_count++;
		end
		if (want.last_parity !== last) begin
			$error("last_parity: expected %0b, actual %0b", want.last_parity, last);
			mismatch_count++;
		end
		beats_matched++;
	endfunction
endclass

module reed_solomon_parity_encoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rspe_pkg::*;

	// Longest stretch without any accepted beat before the run is called hung. The
	// slowest legal gap is the receiver hold-off below plus a generator rebuild.
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_ITEMS = 20;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data  = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata   = '0;
	logic              s_tlast   = 1'b0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [BYTE_W-1:0] m_tdata;
	logic              m_tlast;

	rs_parity_predictor predictor;

	// Shared knobs between the stimulus and the receiver: steady turns off random idling on
	// both sides, hold_ask makes the receiver start a hold-off in which it refuses parity beats.
	bit steady   = 1'b0;
	bit hold_ask = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int count_writes = 0;

	reed_solomon_parity_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// All three channels are sampled at the rising edge, before any of this edge's
	// nonblocking updates land, so a beat is seen exactly when the encoder takes it.
	// Parity beats are matched before a new message byte is noted: a beat leaving at
	// this edge always belongs to an older message.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				predictor.set_parity_count(cfg_data);
			end
			if (m_tvalid && m_tready) begin
				predictor.match_parity_beat(m_tdata, m_tlast);
			end
			if (s_tvalid && s_tready) begin
				predictor.take_message_byte(s_tdata, s_tlast);
			end
		end
	end

	// Watchdog: any accepted beat on any channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (s_tvalid && s_tready)
		    || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Parity receiver. It counts its own hold-off so that the stimulus keeps offering
	// bytes meanwhile; with a full parity row the next last byte must then stall.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_ask) begin
				hold_ask  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= 13);
			end
		end
	end

	task automatic idle_sender();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one message byte and returns at the edge where it is taken. Valid is left
	// high so that back-to-back bytes keep the channel busy without a bubble.
	task automatic send_byte(input logic [7:0] data, input logic last);
		if (!steady) begin
			while ($urandom_range(0, 99) < 13) begin
				idle_sender();
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// Waits until every owed parity beat has left. The first edge lets the monitor note
	// a last byte taken at the edge we returned on; the tail covers the encoder's own
	// pipeline before the register may be touched.
	task automatic drain_parity();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (predictor.parity_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	// Only called with the encoder idle. The rebuild that follows keeps s_tready low,
	// which send_byte simply waits out.
	task automatic write_count(input logic [CFG_W-1:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		count_writes++;
	endtask

	task automatic random_messages(input int budget);
		int sent;
		int len;
		sent = 0;
		while (sent < budget) begin
			// Mostly short messages, now and then a long one to exercise deep remainders.
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
			for (int k = 0; k < len; k++) begin
				send_byte(8'($urandom_range(0, 255)), k == len - 1);
			end
			sent += len;
		end
	endtask

	initial begin
		// The reset is driven low once every process waits, so the encoder sees its edge.
		arst_n <= 1'b0;
		predictor = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset generator, seven parity bytes: an all-zero message gives zero parity,
		// then extreme byte values and single-byte messages.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h55, 1'b1);
		send_byte(8'hFF, 1'b1);

		// A count of zero behaves as one parity byte.
		drain_parity();
		write_count(6'd0);
		send_byte(8'h12, 1'b0);
		send_byte(8'hFF, 1'b1);

		// Counts above the maximum saturate at 32; then 32 itself.
		drain_parity();
		write_count(6'd63);
		send_byte(8'hA5, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		drain_parity();
		write_count(6'd33);
		send_byte(8'h5A, 1'b1);
		drain_parity();
		write_count(6'd32);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b1);

		// A count write in the middle of a message throws away the partial remainder;
		// the bytes after it form a fresh message under the new generator.
		drain_parity();
		send_byte(8'h3C, 1'b0);
		send_byte(8'hC3, 1'b0);
		drain_parity();
		write_count(6'd2);
		send_byte(8'h77, 1'b0);
		send_byte(8'h01, 1'b1);

		// Random phases, each under its own parity count. Phase 2 runs at 32 parity
		// bytes with the receiver held off, so the parity row fills and input stalls.
		// Phase 4 runs with no idling on either side.
		for (int phase = 0; phase < 7; phase++) begin
			drain_parity();
			case (phase)
				0: write_count(6'd1);
				1: write_count(6'($urandom_range(2, 31)));
				2: write_count(6'd63);
				3: write_count(6'd0);
				4: write_count(6'($urandom_range(0, 63)));
				5: write_count(6'd32);
				default: write_count(6'($urandom_range(1, 32)));
			endcase
			steady = (phase == 4);
			if (phase == 2) begin
				hold_ask = 1'b1;
			end
			random_messages(PHASE_ITEMS);
		end
		steady = 1'b0;

		drain_parity();
		repeat (32) @(posedge clk);

		// Anything still owed at this point never arrived.
		if (predictor.parity_due.size() != 0) begin
			$error("%0d parity beats never arrived", predictor.parity_due.size());
			predictor.mismatch_count++;
		end

		$display("Run covered %0d message bytes in %0d messages under %0d parity count writes,",
		         predictor.bytes_taken, predictor.messages_done, count_writes);
		$display("including counts 0, 1, 32, 33 and 63; %0d parity beats checked.",
		         predictor.beats_matched);
		if (predictor.mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/rspe_pkg.sv
rtl/core/rspe_cell.sv
rtl/core/rspe_ctrl.sv
rtl/core/reed_solomon_parity_encoder.sv
test/reed_solomon_parity_encoder_test.sv
